// ----- src/assert_macros.svh -----
// Assertion macros shared by the requantizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_ON(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("requantizer assertion failed");

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("requantizer assertion failed");

`endif

// ----- src/rqc_pkg.sv -----
// Shared types and constants for the int32 requantizer.
`timescale 1ns / 1ps
`default_nettype none

package rqc_pkg;

  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int SHIFT_W = 6;
  localparam int AMT_W = 5;
  localparam int INDEX_W = 3;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [AMT_W-1:0] amt_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_BIAS          = 3'd0,
    REG_MULTIPLIER    = 3'd1,
    REG_SHIFT         = 3'd2,
    REG_ZERO_POINT    = 3'd3,
    REG_CLAMP_MIN     = 3'd4,
    REG_CLAMP_MAX     = 3'd5
  } reg_index_t;

  localparam data_t DATA_MIN = 32'sh8000_0000;
  localparam data_t DATA_MAX = 32'sh7FFF_FFFF;

  // Rounding nudges of the doubling high multiply: +2^30 and 1 - 2^30.
  localparam prod_t NUDGE_POS = 64'sh0000_0000_4000_0000;
  localparam prod_t NUDGE_NEG = 64'shFFFF_FFFF_C000_0001;
  // Added to a negative sum so the shift by 31 truncates toward zero.
  localparam prod_t TRUNC_BIAS = 64'sh0000_0000_7FFF_FFFF;

endpackage

`default_nettype wire

// ----- src/int32_requantize_clamp.sv -----
// Top level of the int32 requantizer: bias, shift, high multiply, round, offset, clamp.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tdata[31:0] accumulator
// m_axis    out  tvalid/tready           tdata[31:0] quantized
// cfg       in   cfg_we                  cfg_index, cfg_wdata
//
// Seven register stages: bias add and left shift, three stages of high
// multiply (product, nudge, truncate), rounding right shift, offset, clamp.
// One request per cycle is accepted while m_axis does not stall.
// Synchronous reset empties the pipeline and zeroes the configuration registers.
// A stall on m_axis backs up stage by stage; empty stages still fill.

module int32_requantize_clamp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // [31:0] accumulator
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // [31:0] quantized
  input  logic                          cfg_we,
  input  logic [rqc_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [rqc_pkg::DATA_W-1:0]    cfg_wdata
);
  import rqc_pkg::*;

  data_t bias;
  data_t multiplier;
  logic [SHIFT_W-1:0] shift;
  data_t zero_point;
  data_t clamp_min;
  data_t clamp_max;

  amt_t left_amt;
  amt_t right_amt;
  logic [SHIFT_W-1:0] shift_neg;

  logic  v1, v5, v6, v7;
  logic  rdy1, rdy5, rdy6, rdy7;
  data_t x1, y5, z6, r7;

  logic  mh_in_ready;
  logic  mh_out_valid;
  data_t mh_q;

  data_t x1_next;
  data_t sum_in;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] thr;
  data_t y5_next;
  data_t lo_clamped;
  data_t r7_next;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bias          <= '0;
      multiplier    <= '0;
      shift         <= '0;
      zero_point    <= '0;
      clamp_min     <= '0;
      clamp_max     <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_BIAS:          bias          <= data_t'(cfg_wdata);
        REG_MULTIPLIER:    multiplier    <= data_t'(cfg_wdata);
        REG_SHIFT:         shift         <= cfg_wdata[SHIFT_W-1:0];
        REG_ZERO_POINT:    zero_point    <= data_t'(cfg_wdata);
        REG_CLAMP_MIN:     clamp_min     <= data_t'(cfg_wdata);
        REG_CLAMP_MAX:     clamp_max     <= data_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // positive shift goes left, otherwise right by -shift, capped at 31
  always_comb begin
    shift_neg = SHIFT_W'(-shift);
    left_amt  = (!shift[SHIFT_W-1] && (shift != '0)) ? shift[AMT_W-1:0] : '0;
    if (!shift[SHIFT_W-1]) begin
      right_amt = '0;
    end else if (shift_neg[SHIFT_W-1]) begin
      right_amt = '1;
    end else begin
      right_amt = shift_neg[AMT_W-1:0];
    end
  end

  // ready chain, last stage first
  assign rdy7          = !v7 || m_axis_tready;
  assign rdy6          = !v6 || rdy7;
  assign rdy5          = !v5 || rdy6;
  assign rdy1          = !v1 || mh_in_ready;
  assign s_axis_tready = rdy1;

  always_comb begin
    sum_in  = data_t'(s_axis_tdata) + bias;
    x1_next = sum_in << left_amt;
  end

  rqc_mulhi u_mulhi (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (mh_in_ready),
    .in_a      (x1),
    .in_b      (multiplier),
    .out_valid (mh_out_valid),
    .out_ready (rdy5),
    .out_q     (mh_q)
  );

  // rounding right shift; the sign bit raises the threshold by one
  always_comb begin
    mask    = (DATA_W'(1) << right_amt) - DATA_W'(1);
    rem     = mh_q & mask;
    thr     = (mask >> 1) + DATA_W'(mh_q[DATA_W-1]);
    y5_next = (mh_q >>> right_amt) + data_t'(rem > thr);
  end

  // lower bound first, so crossed bounds give clamp_max
  always_comb begin
    lo_clamped = (z6 < clamp_min) ? clamp_min : z6;
    r7_next    = (lo_clamped > clamp_max) ? clamp_max : lo_clamped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy5) v5 <= mh_out_valid;
      if (rdy6) v6 <= v5;
      if (rdy7) v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) x1 <= x1_next;
    if (rdy5) y5 <= y5_next;
    if (rdy6) z6 <= y5 + zero_point;
    if (rdy7) r7 <= r7_next;
  end

  assign m_axis_tvalid = v7;
  assign m_axis_tdata  = r7;

  `ASSERT_ON(a_empty_takes_input, !m_axis_tvalid |-> s_axis_tready)
  `ASSERT_ON(a_upper_bound, (v6 && rdy7) |=> (r7 <= $past(clamp_max)))
  `ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> (!m_axis_tvalid && !v1 && !v5 && !v6))

endmodule

`default_nettype wire

// ----- src/rqc_mulhi.sv -----
// Three-stage saturating rounding doubling high multiply.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rqc_mulhi (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rqc_pkg::data_t in_a,
  input  rqc_pkg::data_t in_b,
  output logic          out_valid,
  input  logic          out_ready,
  output rqc_pkg::data_t out_q
);
  import rqc_pkg::*;

  logic  va, vb, vc;
  logic  rdy_a, rdy_b, rdy_c;
  prod_t prod_a;
  logic  sat_a;
  prod_t sum_b;
  logic  sat_b;
  data_t q_c;

  prod_t sum_next;
  prod_t adj;
  data_t q_next;

  assign rdy_c    = !vc || out_ready;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;

  assign out_valid = vc;
  assign out_q     = q_c;

  always_comb begin
    sum_next = prod_a + (prod_a[PROD_W-1] ? NUDGE_NEG : NUDGE_POS);
  end

  always_comb begin
    adj = sum_b[PROD_W-1] ? (sum_b + TRUNC_BIAS) : sum_b;
    // only min * min overflows the quotient
    q_next = sat_b ? DATA_MAX : data_t'(adj[PROD_W-2:DATA_W-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      prod_a <= prod_t'(in_a) * prod_t'(in_b);
      sat_a  <= (in_a == DATA_MIN) && (in_b == DATA_MIN);
    end
    if (rdy_b) begin
      sum_b <= sum_next;
      sat_b <= sat_a;
    end
    if (rdy_c) q_c <= q_next;
  end

  `ASSERT_ON(a_mh_ready_chain, out_ready |-> in_ready)
  `ASSERT_ON(a_mh_saturate, (vb && sat_b && rdy_c) |=> (q_c == DATA_MAX))
  `ASSERT_ALWAYS(a_mh_reset_empty, $past(rst) |-> !out_valid)

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the int32 requantizer with stream handshakes.
`timescale 1ns / 1ps

module tb;
  import rqc_pkg::*;

  localparam int PIPE_LATENCY = 7;
  localparam int QUIET_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata;  // [31:0] accumulator
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [31:0] m_axis_tdata;  // [31:0] quantized
  logic cfg_we;
  logic [INDEX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_wdata;

  // Shadow copy of the scaling registers
  data_t scale_bias;
  data_t scale_mult;
  logic signed [SHIFT_W-1:0] scale_shift;
  data_t zero_point;
  data_t lo_bound;
  data_t hi_bound;

  data_t expected_quantized[$];
  data_t oldest_quantized;
  int error_count;
  int quiet_cycles;
  int ready_stall;
  bit stall_enable;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  int32_requantize_clamp u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  function automatic data_t requantize(logic [31:0] acc);
    logic [31:0] x;
    logic [31:0] mask;
    logic [31:0] rem;
    logic [31:0] thr;
    data_t sx;
    data_t r;
    longint a;
    longint b;
    longint p;
    longint nudge;
    longint q;
    int s;
    int left;
    int right;
    x = acc + scale_bias;
    s = scale_shift;
    left = (s > 0) ? s : 0;
    right = (s > 0) ? 0 : -s;
    if (right > 31) right = 31;
    x = x << left;
    // saturating rounding doubling high multiply
    if (x == 32'h8000_0000 && scale_mult == DATA_MIN) begin
      x = DATA_MAX;
    end else begin
      a = longint'($signed(x));
      b = longint'(scale_mult);
      p = a * b;
      nudge = (p >= 0) ? (longint'(1) << 30) : (longint'(1) - (longint'(1) << 30));
      q = (p + nudge) / (longint'(1) << 31);
      x = q[31:0];
    end
    // round half away from zero on the right shift
    if (right != 0) begin
      mask = (32'd1 << right) - 32'd1;
      rem = x & mask;
      thr = (mask >> 1) + {31'd0, x[31]};
      sx = x;
      sx = sx >>> right;
      x = sx;
      x = x + ((rem > thr) ? 32'd1 : 32'd0);
    end
    x = x + zero_point;
    r = x;
    if (r < lo_bound) r = lo_bound;
    if (r > hi_bound) r = hi_bound;
    return r;
  endfunction

  function automatic data_t random_accumulator();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return $urandom();
    if (pick < 7) return data_t'($urandom_range(0, 65535)) - 32'sd32768;
    if (pick < 9) return $signed($urandom()) >>> $urandom_range(0, 31);
    case ($urandom_range(0, 3))
      0: return DATA_MIN;
      1: return DATA_MAX;
      2: return '0;
      default: return -32'sd1;
    endcase
  endfunction

  task automatic write_register(logic [INDEX_W-1:0] idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_BIAS:          scale_bias = value;
      REG_MULTIPLIER:    scale_mult = value;
      REG_SHIFT:         scale_shift = value[SHIFT_W-1:0];
      REG_ZERO_POINT:    zero_point = value;
      REG_CLAMP_MIN:     lo_bound = value;
      REG_CLAMP_MAX:     hi_bound = value;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_quantized.size() != 0) @(posedge clk);
  endtask

  task automatic configure(data_t b, data_t m, int sh, data_t off, data_t lo, data_t hi);
    logic [31:0] shift_word;
    drain_results();
    // junk in the upper bits; only the low six are kept
    shift_word = $urandom();
    shift_word[SHIFT_W-1:0] = sh[SHIFT_W-1:0];
    write_register(REG_BIAS, b);
    write_register(REG_MULTIPLIER, m);
    write_register(REG_SHIFT, shift_word);
    write_register(REG_ZERO_POINT, off);
    write_register(REG_CLAMP_MIN, lo);
    write_register(REG_CLAMP_MAX, hi);
    end_writes();
  endtask

  task automatic send_accumulator(data_t acc);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= acc;
    do @(posedge clk); while (!s_axis_tready);
    expected_quantized.push_back(requantize(acc));
  endtask

  task automatic sender_gap();
    if (stall_enable && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic randomize_settings();
    data_t b;
    data_t m;
    data_t off;
    data_t lo;
    data_t hi;
    data_t t;
    int sh;
    case ($urandom_range(0, 3))
      0, 1: b = data_t'($urandom_range(0, 131071)) - 32'sd65536;
      2: b = $urandom();
      default: b = '0;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: m = $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
      6, 7: m = $urandom();
      8: m = DATA_MIN;
      default: m = DATA_MAX;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: sh = int'($urandom_range(0, 14)) - 12;
      5, 6, 7: sh = int'($urandom_range(0, 62)) - 31;
      default: begin
        case ($urandom_range(0, 5))
          0: sh = -32;
          1: sh = -31;
          2: sh = 31;
          3: sh = 0;
          4: sh = -1;
          default: sh = 1;
        endcase
      end
    endcase
    case ($urandom_range(0, 2))
      0: off = data_t'($urandom_range(0, 255)) - 32'sd128;
      1: off = $urandom();
      default: off = '0;
    endcase
    lo = $urandom();
    hi = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        lo = -32'sd128;
        hi = 32'sd127;
      end
      4, 5, 6: begin
        lo = DATA_MIN;
        hi = DATA_MAX;
      end
      7, 8: begin
        if (lo > hi) begin
          t = lo;
          lo = hi;
          hi = t;
        end
      end
      default: ;  // possibly crossed bounds
    endcase
    configure(b, m, sh, off, lo, hi);
  endtask

  task automatic test_reset_values();
    send_accumulator($urandom());
    send_accumulator(DATA_MAX);
  endtask

  task automatic test_identity_scale();
    configure('0, DATA_MAX, 0, '0, DATA_MIN, DATA_MAX);
    send_accumulator(32'sd1);
    send_accumulator(-32'sd1);
    send_accumulator(DATA_MAX);
    send_accumulator(DATA_MIN);
    // min times min saturates
    configure('0, DATA_MIN, 0, '0, DATA_MIN, DATA_MAX);
    send_accumulator(DATA_MIN);
    send_accumulator(DATA_MAX);
  endtask

  task automatic test_rounding();
    configure('0, 32'sh4000_0000, 0, '0, DATA_MIN, DATA_MAX);
    send_accumulator(32'sd1);
    send_accumulator(-32'sd1);
    send_accumulator(-32'sd3);
    configure('0, DATA_MAX, -1, '0, DATA_MIN, DATA_MAX);
    send_accumulator(32'sd1);
    send_accumulator(-32'sd1);
    send_accumulator(32'sd3);
    send_accumulator(-32'sd3);
  endtask

  task automatic test_shift_range();
    configure('0, DATA_MAX, -31, '0, DATA_MIN, DATA_MAX);
    send_accumulator(DATA_MAX);
    send_accumulator(DATA_MIN);
    // -32 is limited to a right shift of 31
    configure('0, DATA_MAX, -32, '0, DATA_MIN, DATA_MAX);
    send_accumulator(DATA_MIN);
    send_accumulator(DATA_MAX);
    // bias wrap, then left shift drops the high bits
    configure(DATA_MAX, DATA_MAX, 31, '0, DATA_MIN, DATA_MAX);
    send_accumulator(32'sd1);
    send_accumulator(32'sd2);
  endtask

  task automatic test_offset_clamp();
    configure('0, DATA_MAX, 0, DATA_MAX, DATA_MIN, DATA_MAX);
    send_accumulator(32'sd1);
    // crossed bounds: upper bound wins
    configure('0, DATA_MAX, 0, '0, 32'sd100, -32'sd100);
    send_accumulator('0);
    configure('0, DATA_MAX, -4, 32'sd3, -32'sd128, 32'sd127);
    send_accumulator($urandom());
    send_accumulator(DATA_MAX);
  endtask

  task automatic test_register_decode();
    configure(32'sd5, DATA_MAX, -2, -32'sd7, DATA_MIN, DATA_MAX);
    for (int idx = int'(REG_CLAMP_MAX) + 1; idx < 2 ** INDEX_W; idx++) begin
      write_register(idx[INDEX_W-1:0], $urandom());
    end
    end_writes();
    send_accumulator(random_accumulator());
    send_accumulator(random_accumulator());
  endtask

  task automatic test_random_phases();
    int count;
    for (int phase = 0; phase < 11; phase++) begin
      randomize_settings();
      stall_enable = ($urandom_range(0, 3) != 0);
      count = $urandom_range(90, 130);
      for (int i = 0; i < count; i++) begin
        send_accumulator(random_accumulator());
        sender_gap();
        if (phase == 3 && i == count / 2) drain_results();
      end
    end
  endtask

  task automatic test_back_to_back();
    randomize_settings();
    stall_enable = 1'b0;
    repeat (120) send_accumulator(random_accumulator());
  endtask

  // ready side: random stall bursts
  always @(posedge clk) begin
    if (ready_stall > 0) begin
      ready_stall = ready_stall - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (stall_enable && $urandom_range(0, 9) == 0) ready_stall = $urandom_range(1, 15);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_quantized.size() == 0) begin
        $error("quantized: no request pending, actual %0d", $signed(m_axis_tdata));
        error_count++;
      end else begin
        oldest_quantized = expected_quantized.pop_front();
        if (m_axis_tdata !== oldest_quantized) begin
          $error("quantized: expected %0d, actual %0d", oldest_quantized,
                 $signed(m_axis_tdata));
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    m_axis_tready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    scale_bias = '0;
    scale_mult = '0;
    scale_shift = '0;
    zero_point = '0;
    lo_bound = '0;
    hi_bound = '0;
    error_count = 0;
    quiet_cycles = 0;
    ready_stall = 0;
    stall_enable = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_identity_scale();
    test_rounding();
    test_shift_range();
    test_offset_clamp();
    test_register_decode();
    test_random_phases();
    test_back_to_back();

    drain_results();
    repeat (3 * PIPE_LATENCY) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
